/* sv/rpmm_pkg.sv */
// Shared types and codes for the random projection / min-max normaliser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package rpmm_pkg;

  localparam logic [1:0] KIND_COEF   = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_FETCH  = 2'd2;

  localparam logic [1:0] CFG_ROWS      = 2'd0;
  localparam logic [1:0] CFG_FEATURES  = 2'd1;
  localparam logic [1:0] CFG_PROJECTED = 2'd2;

  localparam int ACC_W = 40;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] item_value;
    logic [7:0]         row_index;
    logic [5:0]         col_index;
  } rpmm_in_t;

  typedef struct packed {
    logic [15:0] normalized_value;
    logic        flat_column;
  } rpmm_out_t;

  typedef enum logic [1:0] {
    OP_COEF   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_FETCH  = 2'd2
  } rpmm_op_t;

  // One classified command as it travels from the front to the back.
  typedef struct packed {
    rpmm_op_t           op;
    logic signed [15:0] value;
    logic [7:0]         row;
    logic [5:0]         col;
    logic               last;
  } rpmm_cmd_t;

endpackage

/* sv/rpmm_front.sv */
// Front end: accepts input beats, drops out-of-range items and queues commands.
// Depends on rpmm_pkg.
`timescale 1ns / 1ps
module rpmm_front import rpmm_pkg::*; #(
  parameter int MAX_ROWS      = 256,
  parameter int MAX_FEATURES  = 64,
  parameter int MAX_PROJECTED = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  rpmm_in_t   in_data,
  input  logic [8:0] rows_cfg,
  input  logic [6:0] feat_cfg,
  input  logic [4:0] proj_cfg,
  output logic       q_valid,
  input  logic       q_ready,
  output rpmm_cmd_t  q_cmd
);

  rpmm_cmd_t  slot_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] count_r;
  int         n_eff, m_eff, mp_eff, row_i, col_i;
  logic       keep;
  rpmm_cmd_t  cmd;
  logic       push, pop;

  always_comb begin
    n_eff  = (int'(rows_cfg) > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
    m_eff  = (int'(feat_cfg) > MAX_FEATURES) ? MAX_FEATURES : int'(feat_cfg);
    mp_eff = (int'(proj_cfg) > MAX_PROJECTED) ? MAX_PROJECTED : int'(proj_cfg);
    row_i  = int'(in_data.row_index);
    col_i  = int'(in_data.col_index);
    cmd.value = in_data.item_value;
    cmd.row   = in_data.row_index;
    cmd.col   = in_data.col_index;
    cmd.last  = (col_i + 1 == m_eff);
    cmd.op    = OP_COEF;
    keep      = 1'b0;
    unique case (in_data.kind)
      KIND_COEF: begin
        cmd.op = OP_COEF;
        keep   = (row_i < MAX_FEATURES) && (col_i < MAX_PROJECTED);
      end
      KIND_SAMPLE: begin
        cmd.op = OP_SAMPLE;
        keep   = (row_i < n_eff) && (col_i < m_eff);
      end
      KIND_FETCH: begin
        cmd.op = OP_FETCH;
        keep   = (row_i < n_eff) && (col_i < mp_eff);
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (count_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop) rptr_r <= ~rptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* sv/rpmm_back.sv */
// Back end: coefficient and projection memories, the shared MAC pipeline,
// column bounds and the serial normalising divider. Depends on rpmm_pkg.
`timescale 1ns / 1ps
module rpmm_back import rpmm_pkg::*; #(
  parameter int MAX_ROWS      = 256,
  parameter int MAX_FEATURES  = 64,
  parameter int MAX_PROJECTED = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  output logic       q_ready,
  input  rpmm_cmd_t  q_cmd,
  input  logic [4:0] proj_cfg,
  output logic       out_valid,
  input  logic       out_ready,
  output rpmm_out_t  out_data
);

  localparam int CAW = (MAX_FEATURES * MAX_PROJECTED > 1) ?
                       $clog2(MAX_FEATURES * MAX_PROJECTED) : 1;
  localparam int PAW = $clog2(MAX_ROWS * MAX_PROJECTED);
  localparam int PW  = (MAX_PROJECTED > 1) ? $clog2(MAX_PROJECTED) : 1;
  localparam int KW  = $clog2(MAX_PROJECTED + 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MAC  = 6'b000010,
    ST_FRD  = 6'b000100,
    ST_FSUB = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_PUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [15:0]      coef_mem [MAX_FEATURES * MAX_PROJECTED];
  logic signed [ACC_W-1:0] proj_mem [MAX_ROWS * MAX_PROJECTED];
  logic signed [ACC_W-1:0] min_mem  [MAX_PROJECTED];
  logic signed [ACC_W-1:0] max_mem  [MAX_PROJECTED];

  rpmm_cmd_t               cmd_r;
  logic [KW-1:0]           k_r, mp_eff;
  logic                    issue_done_r, vld1_r, vld2_r;
  logic [PW-1:0]           k1_r, k2_r;
  logic signed [15:0]      coef_q_r;
  logic signed [ACC_W-1:0] proj_q_r, min_q_r, max_q_r;
  logic signed [31:0]      prod_r;
  logic signed [ACC_W-1:0] acc2_r, min2_r, max2_r;
  logic [ACC_W:0]          rem_r, den_r;
  logic [15:0]             quo_r;
  logic                    flat_r;
  logic [3:0]              cnt_r;
  logic                    out_valid_r;
  rpmm_out_t               out_r;

  logic [PAW-1:0]          proj_raddr, proj_waddr;
  logic [CAW-1:0]          coef_raddr, coef_waddr;
  logic [PW-1:0]           bnd_raddr;
  logic                    coef_we, issue;
  logic signed [ACC_W-1:0] sum;
  logic signed [ACC_W:0]   num, den;
  logic [ACC_W+1:0]        rem2, rem_sub;
  logic                    ge;
  logic                    row_zero;

  assign mp_eff = (int'(proj_cfg) > MAX_PROJECTED) ? KW'(MAX_PROJECTED) : KW'(proj_cfg);
  assign q_ready = (state_r == ST_IDLE);
  assign issue = (state_r == ST_MAC) && !issue_done_r && (k_r < mp_eff);
  assign row_zero = (cmd_r.row == 8'd0);

  always_comb begin
    coef_we    = q_valid && q_ready && (q_cmd.op == OP_COEF);
    coef_waddr = CAW'(int'(q_cmd.row) * MAX_PROJECTED + int'(q_cmd.col));
    coef_raddr = CAW'(int'(cmd_r.col) * MAX_PROJECTED + int'(k_r));
    if (state_r == ST_FRD) begin
      proj_raddr = PAW'(int'(cmd_r.row) * MAX_PROJECTED + int'(cmd_r.col));
      bnd_raddr  = PW'(cmd_r.col);
    end else begin
      proj_raddr = PAW'(int'(cmd_r.row) * MAX_PROJECTED + int'(k_r));
      bnd_raddr  = PW'(k_r);
    end
    proj_waddr = PAW'(int'(cmd_r.row) * MAX_PROJECTED + int'(k2_r));
    // The first feature of a row overwrites the stored projection.
    if (cmd_r.col == 6'd0) sum = ACC_W'(prod_r);
    else sum = acc2_r + ACC_W'(prod_r);
  end

  // Memory ports: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (coef_we) coef_mem[coef_waddr] <= q_cmd.value;
    coef_q_r <= coef_mem[coef_raddr];
  end

  always_ff @(posedge clk) begin
    if (vld2_r) proj_mem[proj_waddr] <= sum;
    proj_q_r <= proj_mem[proj_raddr];
  end

  always_ff @(posedge clk) begin
    if (vld2_r && cmd_r.last && (row_zero || sum < min2_r)) min_mem[k2_r] <= sum;
    if (vld2_r && cmd_r.last && (row_zero || sum > max2_r)) max_mem[k2_r] <= sum;
    min_q_r <= min_mem[bnd_raddr];
    max_q_r <= max_mem[bnd_raddr];
  end

  // MAC pipeline payload: read, multiply, accumulate and write back.
  always_ff @(posedge clk) begin
    if (issue) k1_r <= PW'(k_r);
    prod_r <= coef_q_r * cmd_r.value;
    acc2_r <= proj_q_r;
    min2_r <= min_q_r;
    max2_r <= max_q_r;
    k2_r   <= k1_r;
  end

  always_comb begin
    num     = {proj_q_r[ACC_W-1], proj_q_r} - {min_q_r[ACC_W-1], min_q_r};
    den     = {max_q_r[ACC_W-1], max_q_r} - {min_q_r[ACC_W-1], min_q_r};
    rem2    = {rem_r, 1'b0};
    rem_sub = rem2 - {1'b0, den_r};
    ge      = (rem2 >= {1'b0, den_r});
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_cmd.op == OP_SAMPLE) state_nxt = ST_MAC;
          else if (q_cmd.op == OP_FETCH) state_nxt = ST_FRD;
        end
      end
      ST_MAC:  if (issue_done_r && !vld1_r && !vld2_r) state_nxt = ST_IDLE;
      ST_FRD:  state_nxt = ST_FSUB;
      ST_FSUB: begin
        if (den > 0 && num > 0 && num < den) state_nxt = ST_DIV;
        else state_nxt = ST_PUT;
      end
      ST_DIV:  if (cnt_r == 4'd15) state_nxt = ST_PUT;
      ST_PUT:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      issue_done_r <= 1'b0;
      vld1_r       <= 1'b0;
      vld2_r       <= 1'b0;
      k_r          <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld1_r  <= issue;
      vld2_r  <= vld1_r;
      if (state_r == ST_IDLE) begin
        k_r          <= '0;
        issue_done_r <= 1'b0;
      end else if (state_r == ST_MAC) begin
        if (issue) k_r <= k_r + 1'b1;
        else issue_done_r <= 1'b1;
      end
      if (state_r == ST_PUT && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Fetch datapath: classify the quotient, then one restoring step a cycle.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && q_valid) cmd_r <= q_cmd;
    if (state_r == ST_FSUB) begin
      rem_r  <= num;
      den_r  <= den;
      cnt_r  <= 4'd0;
      flat_r <= !(den > 0);
      if (den > 0 && num >= den && num > 0) quo_r <= 16'hFFFF;
      else quo_r <= 16'd0;
    end else if (state_r == ST_DIV) begin
      cnt_r <= cnt_r + 4'd1;
      quo_r <= {quo_r[14:0], ge};
      rem_r <= ge ? rem_sub[ACC_W:0] : rem2[ACC_W:0];
    end
    if (state_r == ST_PUT && (!out_valid_r || out_ready)) begin
      out_r.normalized_value <= quo_r;
      out_r.flat_column      <= flat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* sv/random_projection_minmax_normalize.sv */
// Random projection with min-max normalisation, top level.
// From the accepting edge, a command waits in the queue until the back end is idle; a coefficient is then
// written to the coefficient memory, a sample is accumulated with one MAC per projected column, and a
// fetch result is offered after the 16-step serial divider, or without it when no division is needed.
// The back end works one item at a time, so a sample, fetch or coefficient waits for the one before;
// a two-entry queue decouples input. Reset is synchronous, active low; memories are not cleared.
`timescale 1ns / 1ps
module random_projection_minmax_normalize import rpmm_pkg::*; #(
  parameter int MAX_ROWS      = 256,
  parameter int MAX_FEATURES  = 64,
  parameter int MAX_PROJECTED = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  rpmm_in_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output rpmm_out_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_wdata
);

  logic [8:0] rows_r;
  logic [6:0] feat_r;
  logic [4:0] proj_r;
  logic       q_valid, q_ready;
  rpmm_cmd_t  q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 9'd256;
      feat_r <= 7'd64;
      proj_r <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS:      rows_r <= cfg_wdata;
        CFG_FEATURES:  feat_r <= cfg_wdata[6:0];
        CFG_PROJECTED: proj_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  rpmm_front #(
    .MAX_ROWS(MAX_ROWS), .MAX_FEATURES(MAX_FEATURES), .MAX_PROJECTED(MAX_PROJECTED)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .rows_cfg(rows_r), .feat_cfg(feat_r), .proj_cfg(proj_r),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  rpmm_back #(
    .MAX_ROWS(MAX_ROWS), .MAX_FEATURES(MAX_FEATURES), .MAX_PROJECTED(MAX_PROJECTED)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .proj_cfg(proj_r),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule

/* test/tb_top.sv */
// Self-checking testbench for random_projection_minmax_normalize.
// Drives coefficient, sample and fetch beats, predicts every normalised result and checks it.
// Depends on rpmm_pkg and the top level of the block only.
`timescale 1ns / 1ps

module tb_top;
  import rpmm_pkg::*;

  class rp_scoreboard;
    logic signed [15:0] coef [1024];
    bit                 coef_ok [1024];
    logic signed [39:0] proj [4096];
    bit                 proj_ok [4096];
    logic signed [39:0] col_lo [16];
    logic signed [39:0] col_hi [16];
    bit                 bound_ok [16];
    int unsigned        rows_reg = 256;
    int unsigned        feats_reg = 64;
    int unsigned        cols_reg = 16;
    rpmm_out_t          awaited [$];
    int                 errors;
    int                 results;

    function int eff_rows();
      return rows_reg > 256 ? 256 : rows_reg;
    endfunction

    function int eff_feats();
      return feats_reg > 64 ? 64 : feats_reg;
    endfunction

    function int eff_cols();
      return cols_reg > 16 ? 16 : cols_reg;
    endfunction

    function void report(string what);
      errors++;
      $display("mismatch: %s", what);
    endfunction

    function void set_reg(logic [1:0] idx, int unsigned val);
      if (idx == CFG_ROWS) rows_reg = val;
      else if (idx == CFG_FEATURES) feats_reg = val;
      else if (idx == CFG_PROJECTED) cols_reg = val;
    endfunction

    // A beat is safe when it reads no store entry that has never been written.
    function bit safe(rpmm_in_t it);
      int n = eff_rows();
      int m = eff_feats();
      int mp = eff_cols();
      if (it.kind == KIND_SAMPLE) begin
        if (it.row_index >= n || it.col_index >= m) return 1;
        for (int k = 0; k < mp; k++) begin
          if (!coef_ok[it.col_index * 16 + k]) return 0;
          if (it.col_index != 0 && !proj_ok[it.row_index * 16 + k]) return 0;
          if (it.col_index + 1 == m && it.row_index != 0 && !bound_ok[k]) return 0;
        end
        return 1;
      end
      if (it.kind == KIND_FETCH) begin
        if (it.row_index >= n || it.col_index >= mp) return 1;
        return proj_ok[it.row_index * 16 + it.col_index] && bound_ok[it.col_index];
      end
      return 1;
    endfunction

    function void note(rpmm_in_t it);
      int n = eff_rows();
      int m = eff_feats();
      int mp = eff_cols();
      int base;
      longint prod;
      longint v;
      longint num;
      longint den;
      rpmm_out_t res;
      base = it.row_index * 16;
      if (it.kind == KIND_COEF) begin
        if (it.row_index < 64 && it.col_index < 16) begin
          coef[it.row_index * 16 + it.col_index] = it.item_value;
          coef_ok[it.row_index * 16 + it.col_index] = 1;
        end
      end else if (it.kind == KIND_SAMPLE) begin
        if (it.row_index < n && it.col_index < m) begin
          for (int k = 0; k < mp; k++) begin
            prod = longint'(it.item_value) * longint'(coef[it.col_index * 16 + k]);
            if (it.col_index == 0) proj[base + k] = prod[39:0];
            else proj[base + k] = proj[base + k] + prod[39:0];
            proj_ok[base + k] = 1;
          end
          if (it.col_index + 1 == m) begin
            for (int k = 0; k < mp; k++) begin
              if (it.row_index == 0) begin
                col_lo[k] = proj[base + k];
                col_hi[k] = proj[base + k];
                bound_ok[k] = 1;
              end else begin
                if (proj[base + k] > col_hi[k]) col_hi[k] = proj[base + k];
                if (proj[base + k] < col_lo[k]) col_lo[k] = proj[base + k];
              end
            end
          end
        end
      end else if (it.kind == KIND_FETCH) begin
        if (it.row_index < n && it.col_index < mp) begin
          v = proj[base + it.col_index];
          num = v - longint'(col_lo[it.col_index]);
          den = longint'(col_hi[it.col_index]) - longint'(col_lo[it.col_index]);
          res.flat_column = 1'b0;
          if (den <= 0) begin
            res.normalized_value = 16'd0;
            res.flat_column = 1'b1;
          end else if (num <= 0) begin
            res.normalized_value = 16'd0;
          end else if (num >= den) begin
            res.normalized_value = 16'hFFFF;
          end else begin
            v = (num <<< 16) / den;
            res.normalized_value = v > 65535 ? 16'hFFFF : v[15:0];
          end
          awaited.push_back(res);
        end
      end
    endfunction

    function void check(rpmm_out_t got);
      rpmm_out_t want;
      results++;
      if (awaited.size() == 0) begin
        report("result beat with nothing awaited");
        return;
      end
      want = awaited.pop_front();
      if (got.normalized_value !== want.normalized_value)
        report($sformatf("normalized_value %0d, predicted %0d",
                         got.normalized_value, want.normalized_value));
      if (got.flat_column !== want.flat_column)
        report($sformatf("flat_column %0b, predicted %0b", got.flat_column, want.flat_column));
    endfunction
  endclass

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 1000000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  rpmm_in_t   in_data;
  logic       out_valid;
  logic       out_ready;
  rpmm_out_t  out_data;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [8:0] cfg_wdata;

  rp_scoreboard sb;
  int  cycles;
  int  beats_sent;
  int  settings_run;
  int  hold_left;
  bit  calm;
  bit  stall_req;

  random_projection_minmax_normalize dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result ready: random, or high when calm; low during a long hold that fills the block up.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_req) begin
        stall_req = 0;
        hold_left = 400;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 25);
      end
    end
  end

  // Sample at the falling edge, so the beat is taken exactly as the rising edge sees it.
  initial begin
    rpmm_out_t got;
    forever begin
      @(negedge clk);
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        got = out_data;
        @(posedge clk);
        sb.check(got);
      end
    end
  end

  function automatic rpmm_in_t beat(logic [1:0] kind, logic signed [15:0] val,
                                    int row, int col);
    rpmm_in_t it;
    it.kind = kind;
    it.item_value = val;
    it.row_index = row[7:0];
    it.col_index = col[5:0];
    return it;
  endfunction

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send(rpmm_in_t it);
    bit hs;
    if (!calm && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do begin
      @(negedge clk);
      hs = in_ready;
      @(posedge clk);
    end while (!hs);
    sb.note(it);
    beats_sent++;
  endtask

  task automatic send_safe(rpmm_in_t it);
    if (sb.safe(it)) send(it);
  endtask

  // Random beat of any kind over the whole field ranges, kept clear of unwritten entries.
  task automatic send_noise();
    rpmm_in_t it;
    for (int tries = 0; tries < 8; tries++) begin
      it = beat(2'($urandom_range(3)), 16'($urandom), $urandom_range(255),
                $urandom_range(63));
      if (sb.safe(it)) begin
        send(it);
        return;
      end
    end
    send(beat(KIND_UNUSED, 16'($urandom), $urandom_range(255), $urandom_range(63)));
  endtask

  task automatic fetch_some(int count);
    int n;
    int mp;
    rpmm_in_t it;
    n = sb.eff_rows();
    mp = sb.eff_cols();
    if (n == 0 || mp == 0) return;
    for (int i = 0; i < count; i++)
      for (int tries = 0; tries < 6; tries++) begin
        it = beat(KIND_FETCH, 16'($urandom), $urandom_range(n - 1), $urandom_range(mp - 1));
        if (sb.safe(it)) begin
          send(it);
          break;
        end
      end
  endtask

  task automatic finish_inflight();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[8:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // One setting: load the coefficients it needs, then walk rows with noise and fetches.
  task automatic run_setting(int unsigned rows, int unsigned feats, int unsigned cols,
                             int row_count);
    int n;
    int m;
    int mp;
    int r;
    finish_inflight();
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_FEATURES, feats);
    write_reg(CFG_PROJECTED, cols);
    settings_run++;
    n = sb.eff_rows();
    m = sb.eff_feats();
    mp = sb.eff_cols();
    if (n == 0 || m == 0 || mp == 0) begin
      repeat (row_count * 4) send_noise();
      return;
    end
    for (int f = 0; f < m; f++)
      for (int k = 0; k < mp; k++)
        if (!sb.coef_ok[f * 16 + k] || $urandom_range(3) == 0)
          send(beat(KIND_COEF, pick_value(), f, k));
    r = 0;
    for (int i = 0; i < row_count; i++) begin
      for (int f = 0; f < m; f++) begin
        // Now and then a row is abandoned half way.
        if (f > 0 && $urandom_range(99) < 4) break;
        send_safe(beat(KIND_SAMPLE, pick_value(), r, f));
        if ($urandom_range(99) < 15) send_noise();
      end
      fetch_some($urandom_range(1, 4));
      if (i == row_count - 2) r = n - 1;
      else if ($urandom_range(99) < 70) r = (r + 1 + $urandom_range(2)) % n;
      else r = $urandom_range(n - 1);
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_ROWS;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme values, ignored beats, and a column whose coefficients are all zero.
    write_reg(CFG_ROWS, 8);
    write_reg(CFG_FEATURES, 2);
    write_reg(CFG_PROJECTED, 3);
    send(beat(KIND_COEF, 16'sh7FFF, 0, 0));
    send(beat(KIND_COEF, 16'sh8000, 0, 1));
    send(beat(KIND_COEF, 16'sh0000, 0, 2));
    send(beat(KIND_COEF, 16'sh8000, 1, 0));
    send(beat(KIND_COEF, 16'sh7FFF, 1, 1));
    send(beat(KIND_COEF, 16'sh0000, 1, 2));
    send(beat(KIND_COEF, 16'sh1234, 255, 63));
    send(beat(KIND_UNUSED, 16'sh7FFF, 255, 63));
    send(beat(KIND_SAMPLE, 16'sh7FFF, 0, 0));
    send(beat(KIND_SAMPLE, 16'sh8000, 0, 1));
    send(beat(KIND_SAMPLE, 16'sh8000, 1, 0));
    send(beat(KIND_SAMPLE, 16'sh8000, 1, 1));
    send(beat(KIND_SAMPLE, 16'sh7FFF, 2, 0));
    send(beat(KIND_SAMPLE, 16'sh7FFF, 2, 1));
    send(beat(KIND_SAMPLE, 16'sh0001, 200, 0));
    send(beat(KIND_SAMPLE, 16'sh0001, 3, 40));
    send(beat(KIND_FETCH, 16'sh0000, 0, 2));
    send(beat(KIND_FETCH, 16'sh0000, 1, 0));
    send(beat(KIND_FETCH, 16'sh0000, 2, 1));
    send(beat(KIND_FETCH, 16'sh0000, 0, 10));
    send(beat(KIND_FETCH, 16'sh0000, 9, 0));

    run_setting(256, 64, 1, 4);
    run_setting(1, 1, 16, 6);
    // Fetches with the result side held off, so that the input queue fills and stalls.
    stall_req = 1;
    calm = 1;
    fetch_some(30);
    calm = 0;
    run_setting(0, 5, 5, 4);
    run_setting(5, 0, 4, 4);
    run_setting(6, 3, 0, 4);
    run_setting(300, 2, 20, 5);
    run_setting(5, 100, 2, 3);
    calm = 1;
    run_setting(12, 4, 16, 8);
    calm = 0;
    while (beats_sent < 1200)
      run_setting($urandom_range(1, 24), $urandom_range(1, 6), $urandom_range(1, 16),
                  $urandom_range(4, 9));

    finish_inflight();
    if (sb.awaited.size() != 0) sb.report("expected results never arrived");
    $display("Sent %0d beats across %0d register settings; %0d results compared.",
             beats_sent, settings_run, sb.results);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
